// File: rtl/detector_readout_word_parser_top_assert.svh
// Assertion macros used by the parser queue module.
`ifndef DETECTOR_READOUT_WORD_PARSER_TOP_ASSERT_SVH
`define DETECTOR_READOUT_WORD_PARSER_TOP_ASSERT_SVH
// Checks that prop holds at every edge outside reset.
`define DRWP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that cons holds in the cycle after ante.
`define DRWP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/drwp_pkg.sv
`default_nettype none
package drwp_pkg;
  typedef enum logic [4:0] {
    PH_IDLE, PH_PCOUNT, PH_PID, PH_SKIP, PH_NODATA, PH_AHDR, PH_ACH, PH_AVAL,
    PH_EOB1, PH_EOB2, PH_THDR, PH_TEVN, PH_TSTART, PH_TSTLO, PH_TDATA, PH_TLO,
    PH_TSKIP, PH_TCOUNT
  } phase_t;

  typedef enum logic [2:0] {
    K_ADC1 = 3'd0, K_ADC2 = 3'd1, K_TSTART = 3'd2, K_TTIME = 3'd3, K_QDC = 3'd4,
    K_SUMMARY = 3'd5
  } kind_t;

  localparam logic CFG_PACKET_ID = 1'b0;
  localparam logic CFG_TDC_SLOT  = 1'b1;

  localparam logic [15:0] PACKET_ID_RST = 16'h5100;
  localparam logic [4:0]  TDC_SLOT_RST  = 5'd20;
  localparam logic [15:0] ALL_ONES      = 16'hFFFF;

  localparam logic [11:0] F_ADC1_NR  = 12'd1;
  localparam logic [11:0] F_ADC1_FF  = 12'd2;
  localparam logic [11:0] F_ADC2_NR  = 12'd4;
  localparam logic [11:0] F_ADC2_FF  = 12'd8;
  localparam logic [11:0] F_TDC_NR   = 12'd16;
  localparam logic [11:0] F_NO_START = 12'd128;
  localparam logic [11:0] F_CH_RANGE = 12'd256;
  localparam logic [11:0] F_EOB_ERR  = 12'd512;
  localparam logic [11:0] F_COUNT    = 12'd1024;
  localparam logic [11:0] F_SLOT     = 12'd2048;

  typedef struct packed {
    logic [15:0] word;
    logic        start;
    logic        is_ones;
    logic [1:0]  ctrl;
    logic        pid_match;
    logic        slot_match;
  } item_t;
endpackage
`default_nettype wire

// File: rtl/detector_readout_word_parser_top.sv
// A word's request passes through the input stage, the queue and the output register after it is accepted.
// Throughput: one word per cycle; the parser takes one word each cycle the output is not stalled.
// Reset (rst_n low at a clock edge) empties the queue and output, waits for an event start,
// and loads packet_id 0x5100 and tdc_slot 20.
`default_nettype none
module detector_readout_word_parser_top
  import drwp_pkg::*;
#(
  parameter int TDC_CHANNELS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [15:0]  in_tdata,   // word
  input  wire logic         in_tuser,   // event_start
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // channel, value, error_mask, multiplicity, hits_a, hits_b, hits_c, hits_d, zero pad
  output logic [111:0]      out_tdata,
  output logic [2:0]        out_tuser,  // kind
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_addr,
  input  wire logic [15:0]  cfg_data
);
  logic        f_valid, q_ready, q_valid, q_pop;
  item_t       f_item, q_head;
  logic [6:0]  ch;
  logic [19:0] val;
  logic [11:0] msk;
  logic [7:0]  mul;
  logic [63:0] hits;

  assign cfg_ready = 1'b1;
  assign out_tdata = {1'b0, hits, mul, msk, val, ch};

  drwp_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_word(in_tdata), .in_start(in_tuser),
    .cfg_valid, .cfg_addr, .cfg_data, .f_valid, .f_ready(q_ready), .f_item
  );

  drwp_queue u_queue (
    .clk, .rst_n, .push(f_valid), .not_full(q_ready), .push_item(f_item),
    .pop(q_pop), .not_empty(q_valid), .head(q_head)
  );

  drwp_back #(.TDC_CHANNELS(TDC_CHANNELS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item(q_head), .out_tvalid, .out_tready,
    .out_kind(out_tuser), .out_channel(ch), .out_value(val), .out_mask(msk),
    .out_mult(mul), .out_hits(hits)
  );
endmodule
`default_nettype wire

// File: rtl/drwp_front.sv
`default_nettype none
module drwp_front
  import drwp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_word,
  input  wire logic        in_start,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_data,
  output logic             f_valid,
  input  wire logic        f_ready,
  output item_t            f_item
);
  logic [15:0] packet_id_r;
  logic [4:0]  tdc_slot_r;
  logic        v_r;
  item_t       item_r;

  assign in_tready = !v_r || f_ready;
  assign f_valid   = v_r;
  assign f_item    = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_id_r <= PACKET_ID_RST;
      tdc_slot_r  <= TDC_SLOT_RST;
    end else if (cfg_valid) begin
      if (cfg_addr == CFG_PACKET_ID) packet_id_r <= cfg_data;
      else tdc_slot_r <= cfg_data[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_tready) begin
      v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.word       <= in_word;
      item_r.start      <= in_start;
      item_r.is_ones    <= (in_word == ALL_ONES);
      item_r.ctrl       <= in_word[6:5];
      item_r.pid_match  <= (in_word == packet_id_r);
      item_r.slot_match <= (in_word[15:11] == tdc_slot_r);
    end
  end
endmodule
`default_nettype wire

// File: rtl/drwp_queue.sv
`default_nettype none
module drwp_queue
  import drwp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  output logic       not_full,
  input  item_t      push_item,
  input  wire logic  pop,
  output logic       not_empty,
  output item_t      head
);
  item_t      mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign not_full  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_item;
  end

  `include "detector_readout_word_parser_top_assert.svh"
  `DRWP_ASSERT(a_cnt_bound, cnt_r != 2'd3, "queue count out of range")
  `DRWP_ASSERT(a_no_pop_empty, !(pop && !not_empty), "pop from empty queue")
  `DRWP_ASSERT_NEXT(a_push_grow, do_push && !do_pop, cnt_r == $past(cnt_r) + 2'd1, "push lost")
endmodule
`default_nettype wire

// File: rtl/drwp_back.sv
`default_nettype none
module drwp_back
  import drwp_pkg::*;
#(
  parameter int TDC_CHANNELS = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_valid,
  output logic         q_pop,
  input  item_t        q_item,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  output logic [2:0]   out_kind,
  output logic [6:0]   out_channel,
  output logic [19:0]  out_value,
  output logic [11:0]  out_mask,
  output logic [7:0]   out_mult,
  output logic [63:0]  out_hits
);
  localparam logic [7:0] TDC_LIM = 8'(TDC_CHANNELS);

  phase_t      phase_r, phase_nxt;
  logic [15:0] ev_r, ev_nxt, pk_r, pk_nxt, pairs_r, pairs_nxt;
  logic [5:0]  bw_r, bw_nxt;
  logic [6:0]  pch_r, pch_nxt;
  logic [3:0]  phi_r, phi_nxt;
  logic [11:0] flags_r, flags_nxt, pflag_r, pflag_nxt;
  logic [7:0]  hcnt_r, hcnt_nxt;
  logic [63:0] hits_r, hits_nxt;
  logic [1:0]  blk_r, blk_nxt;
  logic        ov_r;
  logic [2:0]  kind_r, kind_nxt;
  logic [6:0]  ch_r, ch_nxt;
  logic [19:0] val_r, val_nxt;
  logic [11:0] msk_r, msk_nxt;
  logic [7:0]  mul_r, mul_nxt;
  logic [63:0] oh_r, oh_nxt;
  logic        emit, again, last, adv;
  logic [15:0] w;
  logic [19:0] t;

  assign adv = q_valid && (!ov_r || out_tready);
  assign q_pop = adv;
  assign w = q_item.word;
  assign t = {phi_r, w};
  assign out_tvalid = ov_r;
  assign out_kind = kind_r;
  assign out_channel = ch_r;
  assign out_value = val_r;
  assign out_mask = msk_r;
  assign out_mult = mul_r;
  assign out_hits = oh_r;

  always_comb begin
    phase_nxt = phase_r; ev_nxt = ev_r; pk_nxt = pk_r; pairs_nxt = pairs_r;
    bw_nxt = bw_r; pch_nxt = pch_r; phi_nxt = phi_r; flags_nxt = flags_r;
    pflag_nxt = pflag_r; hcnt_nxt = hcnt_r; hits_nxt = hits_r; blk_nxt = blk_r;
    emit = 1'b0; again = 1'b0; last = (pk_r == 16'd1);
    kind_nxt = 3'd0; ch_nxt = 7'd0; val_nxt = 20'd0; msk_nxt = 12'd0;
    mul_nxt = 8'd0; oh_nxt = 64'd0;
    if (q_item.start) begin
      ev_nxt = (w == 16'd0) ? 16'd0 : w - 16'd1;
      phase_nxt = (ev_nxt != 16'd0) ? PH_PCOUNT : PH_IDLE;
    end else if (phase_r != PH_IDLE) begin
      if (phase_r == PH_PCOUNT) begin
        pk_nxt = (w == 16'd0) ? 16'd0 : w - 16'd1;
        phase_nxt = (pk_nxt != 16'd0) ? PH_PID : PH_PCOUNT;
      end else begin
        if (phase_r >= PH_NODATA && pflag_r != 12'd0) begin
          if (q_item.is_ones) flags_nxt = flags_nxt | pflag_r;
          pflag_nxt = 12'd0;
        end
        again = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (again) begin
            again = 1'b0;
            unique case (phase_nxt)
              PH_PID: begin
                if (q_item.pid_match) begin
                  flags_nxt = 12'd0; hcnt_nxt = 8'd0; pairs_nxt = 16'd0;
                  hits_nxt = 64'd0; blk_nxt = 2'd0; pflag_nxt = 12'd0;
                  bw_nxt = 6'd0; phase_nxt = PH_NODATA;
                end else begin
                  phase_nxt = PH_SKIP;
                end
              end
              PH_NODATA, PH_AHDR: begin
                if (phase_nxt == PH_NODATA && w[9]) begin
                  phase_nxt = PH_AHDR;
                end else if (phase_nxt == PH_NODATA || q_item.is_ones || last) begin
                  again = (phase_nxt == PH_AHDR);
                  if (blk_nxt == 2'd0) flags_nxt = flags_nxt | F_ADC1_NR;
                  else if (blk_nxt == 2'd1) flags_nxt = flags_nxt | F_ADC2_NR;
                  if (blk_nxt == 2'd0) begin
                    blk_nxt = 2'd1; phase_nxt = PH_NODATA;
                  end else if (blk_nxt == 2'd1) phase_nxt = PH_THDR;
                  else phase_nxt = PH_SKIP;
                end else begin
                  bw_nxt = w[13:8];
                  phase_nxt = (bw_nxt != 6'd0) ? PH_ACH : PH_EOB1;
                end
              end
              PH_ACH: begin
                pch_nxt = {1'b0, w[5:0]};
                phase_nxt = PH_AVAL;
              end
              PH_AVAL: begin
                if (w[13:12] == 2'd0 && pch_r < 7'd32) begin
                  emit = 1'b1;
                  kind_nxt = (blk_r == 2'd2) ? 3'(K_QDC) : {1'b0, blk_r};
                  ch_nxt = pch_r; val_nxt = {8'd0, w[11:0]};
                end
                bw_nxt = bw_r - 6'd1;
                phase_nxt = (bw_nxt != 6'd0) ? PH_ACH : PH_EOB1;
              end
              PH_EOB1: phase_nxt = PH_EOB2;
              PH_EOB2: begin
                pflag_nxt = (blk_r == 2'd0) ? F_ADC1_FF :
                            ((blk_r == 2'd1) ? F_ADC2_FF : 12'd0);
                if (blk_r == 2'd0) begin
                  blk_nxt = 2'd1; phase_nxt = PH_NODATA;
                end else if (blk_r == 2'd1) phase_nxt = PH_THDR;
                else phase_nxt = PH_SKIP;
              end
              PH_THDR: begin
                if (q_item.is_ones || last || q_item.ctrl != 2'd2) begin
                  flags_nxt = flags_nxt | F_TDC_NR;
                  emit = 1'b1; kind_nxt = 3'(K_SUMMARY); msk_nxt = flags_nxt;
                  blk_nxt = 2'd2; phase_nxt = PH_NODATA; again = 1'b1;
                end else begin
                  hcnt_nxt = 8'd0; pairs_nxt = 16'd0; hits_nxt = 64'd0;
                  if (!q_item.slot_match) flags_nxt = flags_nxt | F_SLOT;
                  phase_nxt = PH_TEVN;
                end
              end
              PH_TEVN: phase_nxt = PH_TSTART;
              PH_TSTART: begin
                if (q_item.ctrl == 2'd0) begin
                  if (w[7]) begin
                    pch_nxt = w[14:8]; phi_nxt = w[3:0]; phase_nxt = PH_TSTLO;
                  end else begin
                    flags_nxt = flags_nxt | F_NO_START;
                    pairs_nxt = pairs_nxt + 16'd1; phase_nxt = PH_TSKIP;
                  end
                end else begin
                  phase_nxt = PH_TDATA; again = 1'b1;
                end
              end
              PH_TSTLO: begin
                emit = 1'b1; kind_nxt = 3'(K_TSTART); ch_nxt = pch_r; val_nxt = t;
                pairs_nxt = pairs_r + 16'd1; phase_nxt = PH_TDATA;
              end
              PH_TDATA: begin
                if (q_item.ctrl == 2'd0) begin
                  if ({1'b0, w[14:8]} < TDC_LIM) begin
                    pch_nxt = w[14:8]; phi_nxt = w[3:0]; phase_nxt = PH_TLO;
                  end else begin
                    flags_nxt = flags_nxt | F_CH_RANGE;
                    pairs_nxt = pairs_nxt + 16'd1; phase_nxt = PH_TSKIP;
                  end
                end else if (q_item.ctrl == 2'd1) begin
                  if (w[10:8] != 3'd0) flags_nxt = flags_nxt | F_EOB_ERR;
                  phase_nxt = PH_TCOUNT;
                end else begin
                  emit = 1'b1; kind_nxt = 3'(K_SUMMARY); msk_nxt = flags_nxt;
                  mul_nxt = hcnt_nxt; oh_nxt = hits_nxt;
                  blk_nxt = 2'd2; phase_nxt = PH_NODATA; again = 1'b1;
                end
              end
              PH_TLO: begin
                if (hcnt_r != 8'd255) hcnt_nxt = hcnt_r + 8'd1;
                pairs_nxt = pairs_r + 16'd1;
                if (!pch_r[6]) hits_nxt[pch_r[5:0]] = (t != 20'd0);
                emit = 1'b1; kind_nxt = 3'(K_TTIME); ch_nxt = pch_r; val_nxt = t;
                phase_nxt = PH_TDATA;
              end
              PH_TSKIP: phase_nxt = PH_TDATA;
              PH_TCOUNT: begin
                if (w != pairs_r) flags_nxt = flags_nxt | F_COUNT;
                emit = 1'b1; kind_nxt = 3'(K_SUMMARY); msk_nxt = flags_nxt;
                mul_nxt = hcnt_r; oh_nxt = hits_r;
                blk_nxt = 2'd2; phase_nxt = PH_NODATA;
              end
              default: ;
            endcase
          end
        end
        if (pk_nxt != 16'd0) pk_nxt = pk_nxt - 16'd1;
        if (pk_nxt == 16'd0) phase_nxt = PH_PCOUNT;
      end
      if (ev_nxt != 16'd0) ev_nxt = ev_nxt - 16'd1;
      if (ev_nxt == 16'd0) phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; ev_r <= '0; pk_r <= '0; pairs_r <= '0; bw_r <= '0;
      pch_r <= '0; phi_r <= '0; flags_r <= '0; pflag_r <= '0; hcnt_r <= '0;
      hits_r <= '0; blk_r <= '0; ov_r <= 1'b0;
    end else begin
      if (adv) begin
        phase_r <= phase_nxt; ev_r <= ev_nxt; pk_r <= pk_nxt; pairs_r <= pairs_nxt;
        bw_r <= bw_nxt; pch_r <= pch_nxt; phi_r <= phi_nxt; flags_r <= flags_nxt;
        pflag_r <= pflag_nxt; hcnt_r <= hcnt_nxt; hits_r <= hits_nxt; blk_r <= blk_nxt;
      end
      if (adv && emit) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      kind_r <= kind_nxt; ch_r <= ch_nxt; val_r <= val_nxt;
      msk_r <= msk_nxt; mul_r <= mul_nxt; oh_r <= oh_nxt;
    end
  end
endmodule
`default_nettype wire

// File: test/tb_detector_readout_word_parser_top.sv
`default_nettype none
module tb_detector_readout_word_parser_top;
  import drwp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;

  typedef struct {
    kind_t       kind;
    logic [6:0]  ch;
    logic [19:0] val;
    logic [11:0] mask;
    logic [7:0]  mult;
    logic [63:0] hits;
  } hit_t;

  class parse_scoreboard;
    logic [15:0] pid = PACKET_ID_RST;
    logic [4:0]  slot = TDC_SLOT_RST;
    phase_t      ph = PH_IDLE;
    logic [15:0] ev_left = 0, pk_left = 0, pcnt = 0;
    logic [5:0]  blk_left = 0;
    logic [6:0]  pch = 0;
    logic [3:0]  phi = 0;
    logic [11:0] flags = 0, pflag = 0;
    logic [7:0]  hcnt = 0;
    logic [63:0] hbits = 0;
    logic [1:0]  blk = 0;
    hit_t        hits_due[$];
    int          errors = 0;

    function void set_reg(logic addr, logic [15:0] data);
      if (addr == CFG_PACKET_ID) pid = data;
      else slot = data[4:0];
    endfunction

    function void push(kind_t k, logic [6:0] c, logic [19:0] v, logic [11:0] m,
                       logic [7:0] mu, logic [63:0] h);
      hit_t r;
      r.kind = k; r.ch = c; r.val = v; r.mask = m; r.mult = mu; r.hits = h;
      hits_due.push_back(r);
    endfunction

    function void block_done();
      if (blk == 0) begin
        blk = 1; ph = PH_NODATA;
      end else if (blk == 1) begin
        ph = PH_THDR;
      end else begin
        ph = PH_SKIP;
      end
    endfunction

    function void note_request(logic [15:0] w, logic s);
      logic again, last;
      logic [1:0] ctrl;
      logic [19:0] t;
      if (s) begin
        ev_left = (w == 0) ? 16'd0 : w - 16'd1;
        ph = (ev_left != 0) ? PH_PCOUNT : PH_IDLE;
        return;
      end
      if (ph == PH_IDLE) return;
      if (ph == PH_PCOUNT) begin
        pk_left = (w == 0) ? 16'd0 : w - 16'd1;
        ph = (pk_left != 0) ? PH_PID : PH_PCOUNT;
      end else begin
        last = (pk_left == 1);
        if (ph >= PH_NODATA && pflag != 0) begin
          if (w == ALL_ONES) flags |= pflag;
          pflag = 0;
        end
        ctrl = w[6:5];
        do begin
          again = 0;
          case (ph)
            PH_PID: begin
              if (w == pid) begin
                flags = 0; hcnt = 0; pcnt = 0; hbits = 0; blk = 0; pflag = 0;
                blk_left = 0; ph = PH_NODATA;
              end else begin
                ph = PH_SKIP;
              end
            end
            PH_NODATA: begin
              if (w[9]) begin
                ph = PH_AHDR;
              end else begin
                if (blk == 0) flags |= F_ADC1_NR;
                else if (blk == 1) flags |= F_ADC2_NR;
                block_done();
              end
            end
            PH_AHDR: begin
              if (w == ALL_ONES || last) begin
                if (blk == 0) flags |= F_ADC1_NR;
                else if (blk == 1) flags |= F_ADC2_NR;
                block_done();
                again = 1;
              end else begin
                blk_left = w[13:8];
                ph = (blk_left != 0) ? PH_ACH : PH_EOB1;
              end
            end
            PH_ACH: begin
              pch = {1'b0, w[5:0]};
              ph = PH_AVAL;
            end
            PH_AVAL: begin
              if (w[13:12] == 0 && pch < 32)
                push(blk == 2 ? K_QDC : (blk == 1 ? K_ADC2 : K_ADC1), pch,
                     {8'd0, w[11:0]}, 0, 0, 0);
              blk_left = blk_left - 1;
              ph = (blk_left != 0) ? PH_ACH : PH_EOB1;
            end
            PH_EOB1: ph = PH_EOB2;
            PH_EOB2: begin
              pflag = (blk == 0) ? F_ADC1_FF : ((blk == 1) ? F_ADC2_FF : 12'd0);
              block_done();
            end
            PH_THDR: begin
              if (w == ALL_ONES || last || ctrl != 2) begin
                flags |= F_TDC_NR;
                push(K_SUMMARY, 0, 0, flags, 0, 0);
                blk = 2; ph = PH_NODATA; again = 1;
              end else begin
                hcnt = 0; pcnt = 0; hbits = 0;
                if (w[15:11] != slot) flags |= F_SLOT;
                ph = PH_TEVN;
              end
            end
            PH_TEVN: ph = PH_TSTART;
            PH_TSTART: begin
              if (ctrl == 0) begin
                if (w[7]) begin
                  pch = w[14:8]; phi = w[3:0]; ph = PH_TSTLO;
                end else begin
                  flags |= F_NO_START; pcnt++; ph = PH_TSKIP;
                end
              end else begin
                ph = PH_TDATA; again = 1;
              end
            end
            PH_TSTLO: begin
              push(K_TSTART, pch, {phi, w}, 0, 0, 0);
              pcnt++;
              ph = PH_TDATA;
            end
            PH_TDATA: begin
              if (ctrl == 0) begin
                if (w[14:8] < 64) begin
                  pch = w[14:8]; phi = w[3:0]; ph = PH_TLO;
                end else begin
                  flags |= F_CH_RANGE; pcnt++; ph = PH_TSKIP;
                end
              end else if (ctrl == 1) begin
                if (w[10:8] != 0) flags |= F_EOB_ERR;
                ph = PH_TCOUNT;
              end else begin
                push(K_SUMMARY, 0, 0, flags, hcnt, hbits);
                blk = 2; ph = PH_NODATA; again = 1;
              end
            end
            PH_TLO: begin
              t = {phi, w};
              if (hcnt < 255) hcnt++;
              pcnt++;
              if (pch < 64) hbits[pch[5:0]] = (t != 0);
              push(K_TTIME, pch, t, 0, 0, 0);
              ph = PH_TDATA;
            end
            PH_TSKIP: ph = PH_TDATA;
            PH_TCOUNT: begin
              if (w != pcnt) flags |= F_COUNT;
              push(K_SUMMARY, 0, 0, flags, hcnt, hbits);
              blk = 2; ph = PH_NODATA;
            end
            default: ;
          endcase
        end while (again);
        if (pk_left != 0) pk_left--;
        if (pk_left == 0) ph = PH_PCOUNT;
      end
      if (ev_left != 0) ev_left--;
      if (ev_left == 0) ph = PH_IDLE;
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $display("%0t mismatch %s expected %0h actual %0h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [111:0] d);
      hit_t e;
      if (hits_due.size() == 0) begin
        $display("%0t unexpected result kind %0d data %0h", $time, kind, d);
        errors++;
        return;
      end
      e = hits_due.pop_front();
      cmp("kind", e.kind, kind);
      cmp("channel", e.ch, d[6:0]);
      cmp("value", e.val, d[26:7]);
      cmp("error_mask", e.mask, d[38:27]);
      cmp("multiplicity", e.mult, d[46:39]);
      cmp("hits", e.hits, d[110:47]);
      cmp("pad", 0, d[111]);
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tuser = 0, out_tready = 0, cfg_valid = 0, cfg_addr = 0;
  logic [15:0] in_tdata = 0, cfg_data = 0;
  logic in_tready, out_tvalid, cfg_ready;
  logic [111:0] out_tdata;
  logic [2:0] out_tuser;

  parse_scoreboard sb = new();
  int in_count = 0, cfg_count = 0, cycles = 0, burst_left = 0, sent = 0;
  int stall_mode = 0;
  logic [15:0] cur_pid = PACKET_ID_RST;
  logic [4:0]  cur_slot = TDC_SLOT_RST;
  logic [15:0] body[$];
  logic [16:0] ev_q[$];

  detector_readout_word_parser_top dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_request(in_tdata, in_tuser);
        in_count++;
      end
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if (cfg_valid && cfg_ready) begin
        sb.set_reg(cfg_addr, cfg_data);
        cfg_count++;
      end
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= (cycles % 16) < 11;
    endcase
  end

  task automatic write_reg(logic addr, logic [15:0] data);
    int n0;
    n0 = cfg_count;
    cfg_valid = 1; cfg_addr = addr; cfg_data = data;
    do @(negedge clk); while (cfg_count == n0);
    cfg_valid = 0;
  endtask

  task automatic send_word(logic [15:0] w, logic s);
    int n0;
    if (burst_left == 0) begin
      in_tvalid = 0;
      in_tdata = $urandom;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    n0 = in_count;
    in_tvalid = 1; in_tdata = w; in_tuser = s;
    do @(negedge clk); while (in_count == n0);
    burst_left--;
    sent++;
    if (burst_left == 0) in_tvalid = 0;
  endtask

  task automatic drain();
    in_tvalid = 0;
    while (sb.hits_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [15:0] rnd16();
    return $urandom;
  endfunction

  function automatic void add_adc();
    int n;
    case ($urandom_range(0, 9))
      0: body.push_back(rnd16() & 16'hFDFF);
      1: begin
        body.push_back(rnd16() | 16'h0200);
        body.push_back(ALL_ONES);
      end
      default: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 62) : $urandom_range(0, 4);
        body.push_back(rnd16() | 16'h0200);
        body.push_back({2'($urandom_range(0, 3)), n[5:0], 8'($urandom_range(0, 255))});
        repeat (n) begin
          body.push_back((rnd16() & 16'hFFC0) | 16'($urandom_range(0, 37)));
          if ($urandom_range(0, 5) == 0) body.push_back(rnd16());
          else body.push_back({2'($urandom_range(0, 3)), 2'b00, 12'($urandom)});
        end
        body.push_back(rnd16());
        body.push_back(rnd16());
        if ($urandom_range(0, 3) == 0) body.push_back(ALL_ONES);
      end
    endcase
  endfunction

  function automatic void add_tdc();
    int n, pc;
    logic [6:0] ch;
    pc = 0;
    case ($urandom_range(0, 9))
      0: body.push_back(ALL_ONES);
      1: body.push_back(rnd16() ^ 16'h0040);
      default: begin
        body.push_back({($urandom_range(0, 5) == 0) ? 5'($urandom) : cur_slot,
                        4'($urandom), 2'b10, 5'($urandom)});
        body.push_back(rnd16());
        case ($urandom_range(0, 7))
          0: begin
            body.push_back({1'($urandom), 7'($urandom), 1'b0, 2'b00, 5'($urandom)});
            body.push_back(rnd16());
            pc++;
          end
          1: ;
          default: begin
            body.push_back({1'($urandom), 7'($urandom), 1'b1, 2'b00, 5'($urandom)});
            body.push_back(rnd16());
            pc++;
          end
        endcase
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 6);
        repeat (n) begin
          ch = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 63));
          body.push_back({1'($urandom), ch, 1'($urandom), 2'b00, 5'($urandom)});
          body.push_back(($urandom_range(0, 4) == 0) ? 16'd0 : rnd16());
          pc++;
        end
        if ($urandom_range(0, 7) == 0) begin
          body.push_back({9'($urandom), 2'($urandom_range(2, 3)), 5'($urandom)});
        end else begin
          body.push_back({5'($urandom), ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'd0,
                          1'($urandom), 2'b01, 5'($urandom)});
          body.push_back(($urandom_range(0, 7) == 0) ? rnd16() : 16'(pc));
        end
      end
    endcase
  endfunction

  task automatic send_event();
    int total, p;
    ev_q.delete();
    repeat ($urandom_range(1, 3)) begin
      body.delete();
      if ($urandom_range(0, 4) != 0) begin
        body.push_back(cur_pid);
        add_adc();
        add_adc();
        add_tdc();
        add_adc();
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) body.push_back(rnd16());
      end else begin
        body.push_back(cur_pid ^ 16'($urandom_range(1, 65535)));
        repeat ($urandom_range(0, 5)) body.push_back(rnd16());
      end
      p = body.size() + 1;
      if ($urandom_range(0, 9) == 0) p = $urandom_range(0, p);
      ev_q.push_back({1'b0, 16'(p)});
      foreach (body[i]) ev_q.push_back({1'b0, body[i]});
    end
    total = ev_q.size() + 1;
    if ($urandom_range(0, 9) == 0) total = $urandom_range(0, total + 3);
    send_word(16'(total), 1'b1);
    foreach (ev_q[i]) send_word(ev_q[i][15:0], ev_q[i][16]);
  endtask

  task automatic set_regs(logic [15:0] pid, logic [4:0] slot);
    drain();
    write_reg(CFG_PACKET_ID, pid);
    write_reg(CFG_TDC_SLOT, slot);
    cur_pid = pid;
    cur_slot = slot;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1;
    send_word(16'h1234, 1'b0);
    send_word(16'd0, 1'b1);
    send_word(16'hFFFF, 1'b0);
    send_word(16'd1, 1'b1);
    send_word(16'h5100, 1'b0);
    send_word(16'd9, 1'b1);
    send_word(16'd1, 1'b0);
    send_word(16'd3, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'hAAAA, 1'b0);
    send_word(16'd4, 1'b0);
    send_word(cur_pid, 1'b0);
    send_word(16'h0200, 1'b0);
    send_word(ALL_ONES, 1'b0);
    send_word(16'd30, 1'b1);
    send_word(16'd6, 1'b0);
    send_word(cur_pid, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(ALL_ONES, 1'b0);
    send_word(16'h0200, 1'b0);
    send_word(16'd12, 1'b1);
    while (sent < 180) send_event();
    set_regs(16'h0000, 5'd0);
    while (sent < 330) send_event();
    set_regs(16'hFFFF, 5'd31);
    while (sent < 480) send_event();
    set_regs(rnd16(), 5'($urandom));
    while (sent < 600) send_event();
    set_regs(PACKET_ID_RST, TDC_SLOT_RST);
    while (sent < 720) send_event();
    in_tvalid = 0;
    drain();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.hits_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/drwp_pkg.sv
rtl/drwp_front.sv
rtl/drwp_queue.sv
rtl/drwp_back.sv
rtl/detector_readout_word_parser_top.sv
test/tb_detector_readout_word_parser_top.sv
